FILE: rtl/core/hlmr_pkg.sv
`timescale 1ns / 1ps
package hlmr_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int THRESH_W   = 15;
  localparam int LOSS_W     = 32;
  localparam int SUM_W      = 48;
  localparam int MEAN_W     = 32;
  localparam int COUNT_OUT_W = 17;
  localparam int OPND_W     = 17;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd256;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Divider step count: one quotient bit per cycle over the sum width
  localparam int DIV_STEP_W = $clog2(SUM_W);
  localparam logic [DIV_STEP_W-1:0] DIV_LAST_STEP = DIV_STEP_W'(SUM_W - 1);

  // One element loss on its way from front to back
  typedef struct packed {
    logic [LOSS_W-1:0] loss;
    logic              last;
  } hlmr_entry_t;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_DIV,
    BK_PUT
  } hlmr_back_state_t;

endpackage

FILE: rtl/core/hlmr_in_if.sv
`timescale 1ns / 1ps
interface hlmr_in_if import hlmr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] prediction;
  logic signed [SAMPLE_W-1:0] target;
  logic                       last_element;

  modport source (output valid, output prediction, output target, output last_element,
                  input ready);
  modport sink   (input valid, input prediction, input target, input last_element,
                  output ready);
endinterface

FILE: rtl/core/hlmr_out_if.sv
`timescale 1ns / 1ps
interface hlmr_out_if import hlmr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MEAN_W-1:0]      mean_loss;
  logic [COUNT_OUT_W-1:0] element_count;

  modport source (output valid, output mean_loss, output element_count, input ready);
  modport sink   (input valid, input mean_loss, input element_count, output ready);
endinterface

FILE: rtl/core/hlmr_front.sv
`timescale 1ns / 1ps
module hlmr_front import hlmr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [THRESH_W-1:0] threshold,
  hlmr_in_if.sink             samples,
  output logic                push_valid,
  input  logic                push_ready,
  output hlmr_entry_t         push_data
);

  logic                    s1_valid;
  logic [OPND_W-1:0]       s1_a;
  logic [OPND_W-1:0]       s1_b;
  logic                    s1_last;
  logic                    s2_valid;
  hlmr_entry_t             s2_entry;

  logic                    adv1;
  logic                    adv2;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]       diff_abs;
  logic [SAMPLE_W-1:0]     d;
  logic                    quad;
  logic [OPND_W-1:0]       opnd_a;
  logic [OPND_W-1:0]       opnd_b;
  logic [2*OPND_W-1:0]     prod;

  // Advance a stage when the one after it is empty or moving
  assign adv2 = !s2_valid || push_ready;
  assign adv1 = !s1_valid || adv2;
  assign samples.ready = adv1;

  // Classify: absolute difference against the threshold, pick multiplier operands
  always_comb begin
    diff     = {samples.prediction[SAMPLE_W-1], samples.prediction}
             - {samples.target[SAMPLE_W-1], samples.target};
    diff_abs = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    d        = diff_abs[SAMPLE_W-1:0];
    quad     = {1'b0, d} <= {2'b00, threshold};
    if (quad) begin
      opnd_a = {1'b0, d};
      opnd_b = {1'b0, d};
    end else begin
      opnd_a = {2'b00, threshold};
      opnd_b = {d, 1'b0} - {2'b00, threshold};
    end
  end

  // Stage 1: hold operands
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= samples.valid;
    end
    if (adv1) begin
      s1_a    <= opnd_a;
      s1_b    <= opnd_b;
      s1_last <= samples.last_element;
    end
  end

  // Stage 2: multiply and halve
  assign prod = s1_a * s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2) begin
      s2_entry.loss <= prod[LOSS_W:1];
      s2_entry.last <= s1_last;
    end
  end

  assign push_valid = s2_valid;
  assign push_data  = s2_entry;

endmodule

FILE: rtl/core/hlmr_fifo.sv
`timescale 1ns / 1ps
module hlmr_fifo import hlmr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  hlmr_entry_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output hlmr_entry_t pop_data
);

  hlmr_entry_t         slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = fill != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store a beat
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

FILE: rtl/core/hlmr_back.sv
`timescale 1ns / 1ps
module hlmr_back import hlmr_pkg::*; #(
  parameter int MAX_ELEMENTS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  hlmr_entry_t pop_data,
  hlmr_out_if.source  result
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int EW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  hlmr_back_state_t state;
  hlmr_back_state_t state_next;

  logic [SUM_W-1:0]      loss_sum;
  logic [CW-1:0]         items_seen;
  logic [SUM_W-1:0]      sum_next;
  logic [CW-1:0]         count_next;
  logic [SUM_W:0]        sum_add;
  logic                  take;

  logic [SUM_W-1:0]      div_num;
  logic [CW-1:0]         div_den;
  logic [CW-1:0]         div_rem;
  logic [DIV_STEP_W-1:0] div_step;
  logic [CW:0]           rem_shift;
  logic                  rem_ge;

  logic                  out_valid;
  logic [MEAN_W-1:0]     out_mean;
  logic [COUNT_OUT_W-1:0] out_count;
  logic                  load_out;
  logic [EW-1:0]         den_ext;

  // Saturating accumulate, skipped once the count is full
  always_comb begin
    sum_add    = {1'b0, loss_sum} + {{(SUM_W + 1 - LOSS_W){1'b0}}, pop_data.loss};
    sum_next   = loss_sum;
    count_next = items_seen;
    if (items_seen < CW'(MAX_ELEMENTS)) begin
      sum_next   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      count_next = items_seen + 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_ACC: if (pop_valid && pop_data.last) state_next = BK_DIV;
      BK_DIV: if (div_step == DIV_LAST_STEP) state_next = BK_PUT;
      BK_PUT: if (!out_valid || result.ready) state_next = BK_ACC;
      default: state_next = BK_ACC;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop_ready = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      BK_ACC: pop_ready = 1'b1;
      BK_DIV: pop_ready = 1'b0;
      BK_PUT: load_out  = !out_valid || result.ready;
      default: pop_ready = 1'b0;
    endcase
  end

  assign take = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= BK_ACC;
    else     state <= state_next;
  end

  // Hold the running sum and count; clear them when a tensor closes
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_sum   <= '0;
      items_seen <= '0;
    end else if (take) begin
      if (pop_data.last) begin
        loss_sum   <= '0;
        items_seen <= '0;
      end else begin
        loss_sum   <= sum_next;
        items_seen <= count_next;
      end
    end
  end

  // Restoring divide, one quotient bit per cycle
  assign rem_shift = {div_rem, div_num[SUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (take && pop_data.last) begin
      div_num  <= sum_next;
      div_den  <= count_next;
      div_rem  <= '0;
      div_step <= '0;
    end else if (state == BK_DIV) begin
      div_rem  <= rem_ge ? CW'(rem_shift - {1'b0, div_den}) : rem_shift[CW-1:0];
      div_num  <= {div_num[SUM_W-2:0], rem_ge};
      div_step <= div_step + 1'b1;
    end
  end

  // Output register: saturate the quotient and hold until taken
  assign den_ext = EW'(div_den);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_mean  <= (div_num[SUM_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}} : div_num[MEAN_W-1:0];
      out_count <= den_ext[COUNT_OUT_W-1:0];
    end
  end

  assign result.valid         = out_valid;
  assign result.mean_loss     = out_mean;
  assign result.element_count = out_count;

endmodule

FILE: rtl/core/huber_loss_mean_reducer.sv
`timescale 1ns / 1ps
// Huber loss mean reducer. Prediction/target pairs in signed Q8.8 arrive on
// samples, one beat per cycle while ready is high; the element loss (d*d/2
// for d at or below the threshold, delta*(d - delta/2) above it, Q16.16) is
// summed into a saturating 48-bit accumulator and counted, up to MAX_ELEMENTS
// elements per tensor. A beat with last_element set closes the tensor and
// yields one beat on result: the floor of sum/count saturated to 32 bits, and
// the element count. Items flow at one per cycle, unless stalled, through a
// two-stage classify/multiply front and a four-entry queue; the back
// accumulates one per cycle while it is not dividing or presenting a result.
// Closing a tensor runs a bit-serial divider and then loads the output
// register; the closing beat passes both front stages and the queue before it
// reaches the back, and the result is held until the receiver takes it. The
// front keeps accepting until the queue and both of its stages fill. The
// threshold register (reset 256, i.e. 1.0, smooth L1) is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which the block does not enforce.
module huber_loss_mean_reducer import hlmr_pkg::*; #(
  parameter int MAX_ELEMENTS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [THRESH_W-1:0] cfg_wdata,
  hlmr_in_if.sink             samples,
  hlmr_out_if.source          result
);

  logic [THRESH_W-1:0] huber_threshold;
  logic                push_valid;
  logic                push_ready;
  hlmr_entry_t         push_data;
  logic                pop_valid;
  logic                pop_ready;
  hlmr_entry_t         pop_data;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      huber_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      huber_threshold <= cfg_wdata;
    end
  end

  hlmr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .threshold  (huber_threshold),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  hlmr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hlmr_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

FILE: dv/tb_huber_loss_mean_reducer.sv
`timescale 1ns / 1ps
module tb_huber_loss_mean_reducer;
  import hlmr_pkg::*;

  localparam int ELEM_CAP     = 65536;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 64;
  localparam int BEATS_PER_PHASE = 170;
  localparam logic [SUM_W-1:0] SUM_CEIL = '1;

  typedef enum bit {ROW_BEAT, ROW_THRESH} row_kind_t;
  typedef enum bit [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_THIRD} rx_mode_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prediction;
    logic signed [SAMPLE_W-1:0] target;
    logic                       last_element;
  } sample_beat_t;

  typedef struct packed {
    logic [MEAN_W-1:0]      mean_loss;
    logic [COUNT_OUT_W-1:0] element_count;
  } mean_result_t;

  typedef struct {
    row_kind_t              kind;
    int                     pred;
    int                     targ;
    bit                     last;
    logic [THRESH_W-1:0]    thresh;
    bit                     typed;
    logic [MEAN_W-1:0]      want_mean;
    logic [COUNT_OUT_W-1:0] want_count;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [THRESH_W-1:0] cfg_wdata;

  hlmr_in_if  samples_if ();
  hlmr_out_if result_if ();

  huber_loss_mean_reducer #(
    .MAX_ELEMENTS(ELEM_CAP)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .samples  (samples_if),
    .result   (result_if)
  );

  // Predictor state: threshold, running sum and element tally of the open tensor
  logic [THRESH_W-1:0] delta_q;
  logic [SUM_W-1:0]    loss_total;
  int                  elems_in_tensor;

  mean_result_t pending_means[$];

  int  errors;
  int  beats_sent;
  int  tensors_closed;
  int  means_checked;
  int  thresh_writes;
  int  widest_tensor;
  int  cycle_count;
  int  burst_left;
  int  max_gap;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Fold one accepted beat into the running sum; return the mean on a closing beat
  task automatic fold_element(input sample_beat_t s, output bit closes,
                              output mean_result_t r);
    int          diff;
    logic [15:0] d;
    logic [63:0] term;
    logic [63:0] total;
    logic [63:0] quot;
    diff = int'(s.prediction) - int'(s.target);
    d = 16'(diff < 0 ? -diff : diff);
    if (elems_in_tensor < ELEM_CAP) begin
      if (d <= delta_q) term = (64'(d) * 64'(d)) >> 1;
      else term = (64'(delta_q) * (2 * 64'(d) - 64'(delta_q))) >> 1;
      total = 64'(loss_total) + term;
      loss_total = (total > 64'(SUM_CEIL)) ? SUM_CEIL : total[SUM_W-1:0];
      elems_in_tensor++;
    end
    closes = s.last_element;
    r = '0;
    if (closes) begin
      quot = 64'(loss_total) / 64'(elems_in_tensor);
      r.mean_loss = (quot > 64'hFFFF_FFFF) ? '1 : quot[MEAN_W-1:0];
      r.element_count = COUNT_OUT_W'(elems_in_tensor);
      if (elems_in_tensor > widest_tensor) widest_tensor = elems_in_tensor;
      tensors_closed++;
      loss_total = '0;
      elems_in_tensor = 0;
    end
  endtask

  // Present a beat and hold it until the block takes it
  task automatic offer_beat(input sample_beat_t s, input bit typed, input mean_result_t want);
    bit           closes;
    mean_result_t r;
    samples_if.valid        <= 1'b1;
    samples_if.prediction   <= s.prediction;
    samples_if.target       <= s.target;
    samples_if.last_element <= s.last_element;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    fold_element(s, closes, r);
    if (closes) pending_means.push_back(typed ? want : r);
    beats_sent++;
  endtask

  // Sender bursts: random burst length, then a random gap with valid low
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_gap);
      if (gap > 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait for every outstanding mean, then let the pipeline drain
  task automatic settle();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THRESH_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    delta_q = v;
    thresh_writes++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] extreme_sample();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Random pair: mostly uniform, some extremes, some straddling the threshold
  function automatic sample_beat_t draw_sample(input bit closes);
    sample_beat_t s;
    int           off;
    s.target = SAMPLE_W'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        s.prediction = extreme_sample();
        s.target     = extreme_sample();
      end
      1, 2: begin
        off = int'(delta_q) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) off = -off;
        s.prediction = SAMPLE_W'(int'(s.target) + off);
      end
      default: s.prediction = SAMPLE_W'($urandom);
    endcase
    s.last_element = closes;
    return s;
  endfunction

  // Receiver: rotating stall patterns, plus a long hold-off on request
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    span = 0;
    mode = RX_OPEN;
    result_if.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          result_if.ready <= 1'b0;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(32, 256);
        end
        span--;
        case (mode)
          RX_OPEN:   result_if.ready <= 1'b1;
          RX_COIN:   result_if.ready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: result_if.ready <= ($urandom_range(0, 3) != 0);
          default:   result_if.ready <= (span % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest expected mean
  always @(posedge clk) begin
    mean_result_t want;
    if (result_if.valid && result_if.ready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result beat: mean_loss=%0d element_count=%0d", $time,
                 result_if.mean_loss, result_if.element_count);
        errors++;
      end else begin
        want = pending_means.pop_front();
        means_checked++;
        if (result_if.mean_loss !== want.mean_loss) begin
          $display("%0t: mean_loss mismatch: expected %0d, got %0d", $time,
                   want.mean_loss, result_if.mean_loss);
          errors++;
        end
        if (result_if.element_count !== want.element_count) begin
          $display("%0t: element_count mismatch: expected %0d, got %0d", $time,
                   want.element_count, result_if.element_count);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached with %0d means outstanding", $time,
             pending_means.size());
    $display("tb_huber_loss_mean_reducer failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t           directed_rows[$];
    stim_row_t           row;
    sample_beat_t        s;
    mean_result_t        want;
    logic [THRESH_W-1:0] phase_thresh[6];
    int                  phase_beats;
    int                  len;

    errors          = 0;
    beats_sent      = 0;
    tensors_closed  = 0;
    means_checked   = 0;
    thresh_writes   = 0;
    widest_tensor   = 0;
    burst_left      = 0;
    max_gap         = 6;
    hold_req        = 1'b0;
    delta_q         = THRESH_RESET;
    loss_total      = '0;
    elems_in_tensor = 0;

    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= '0;
    samples_if.valid        <= 1'b0;
    samples_if.prediction   <= '0;
    samples_if.target       <= '0;
    samples_if.last_element <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes and branch edges at the reset threshold (1.0)
    directed_rows.push_back('{ROW_BEAT, 0, 0, 1'b1, 15'd0, 1'b1, 32'd0, 17'd1});
    directed_rows.push_back('{ROW_BEAT, 256, 0, 1'b1, 15'd0, 1'b1, 32'd32768, 17'd1});
    directed_rows.push_back('{ROW_BEAT, 0, 257, 1'b1, 15'd0, 1'b1, 32'd33024, 17'd1});
    directed_rows.push_back('{ROW_BEAT, 32767, -32768, 1'b1, 15'd0, 1'b1, 32'd16744192, 17'd1});
    directed_rows.push_back('{ROW_BEAT, -32768, 32767, 1'b1, 15'd0, 1'b1, 32'd16744192, 17'd1});
    directed_rows.push_back('{ROW_BEAT, -32768, -32768, 1'b1, 15'd0, 1'b1, 32'd0, 17'd1});
    // halving truncates
    directed_rows.push_back('{ROW_BEAT, 1, 0, 1'b1, 15'd0, 1'b1, 32'd0, 17'd1});
    directed_rows.push_back('{ROW_BEAT, 3, 0, 1'b1, 15'd0, 1'b1, 32'd4, 17'd1});
    // multi-element tensors, division truncates
    directed_rows.push_back('{ROW_BEAT, 512, 0, 1'b0, 15'd0, 1'b0, 32'd0, 17'd0});
    directed_rows.push_back('{ROW_BEAT, -512, 0, 1'b0, 15'd0, 1'b0, 32'd0, 17'd0});
    directed_rows.push_back('{ROW_BEAT, 100, -100, 1'b1, 15'd0, 1'b0, 32'd0, 17'd0});
    directed_rows.push_back('{ROW_BEAT, 255, 0, 1'b0, 15'd0, 1'b0, 32'd0, 17'd0});
    directed_rows.push_back('{ROW_BEAT, -256, 0, 1'b1, 15'd0, 1'b0, 32'd0, 17'd0});
    // zero threshold: every loss is zero
    directed_rows.push_back('{ROW_THRESH, 0, 0, 1'b0, 15'd0, 1'b0, 32'd0, 17'd0});
    directed_rows.push_back('{ROW_BEAT, 1000, 0, 1'b1, 15'd0, 1'b1, 32'd0, 17'd1});
    directed_rows.push_back('{ROW_BEAT, 0, 0, 1'b1, 15'd0, 1'b1, 32'd0, 17'd1});
    // largest threshold: largest losses of both branches
    directed_rows.push_back('{ROW_THRESH, 0, 0, 1'b0, 15'd32767, 1'b0, 32'd0, 17'd0});
    directed_rows.push_back('{ROW_BEAT, 32767, -32768, 1'b1, 15'd0, 1'b1, 32'd1610547200,
                              17'd1});
    directed_rows.push_back('{ROW_BEAT, 32767, 0, 1'b1, 15'd0, 1'b1, 32'd536838144, 17'd1});
    directed_rows.push_back('{ROW_BEAT, -32768, -1, 1'b1, 15'd0, 1'b1, 32'd536838144, 17'd1});
    directed_rows.push_back('{ROW_THRESH, 0, 0, 1'b0, THRESH_RESET, 1'b0, 32'd0, 17'd0});

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_THRESH) begin
        set_threshold(row.thresh);
      end else begin
        s.prediction   = SAMPLE_W'(row.pred);
        s.target       = SAMPLE_W'(row.targ);
        s.last_element = row.last;
        want.mean_loss     = row.want_mean;
        want.element_count = row.want_count;
        offer_beat(s, row.typed, want);
        pace();
      end
    end
    settle();

    // Hold off the receiver while single-element tensors keep coming, so the block backs up
    hold_req = 1'b1;
    repeat (24) offer_beat(draw_sample(1'b1), 1'b0, '0);
    settle();

    // Random tensors over several thresholds
    phase_thresh[0] = 15'd0;
    phase_thresh[1] = 15'd32767;
    phase_thresh[2] = 15'd1;
    phase_thresh[3] = 15'($urandom_range(0, 32767));
    phase_thresh[4] = 15'($urandom_range(0, 1023));
    phase_thresh[5] = THRESH_RESET;
    foreach (phase_thresh[p]) begin
      set_threshold(phase_thresh[p]);
      phase_beats = 0;
      while (phase_beats < BEATS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(21, 64);
          1, 2, 3: len = $urandom_range(5, 20);
          default: len = $urandom_range(1, 4);
        endcase
        for (int k = 0; k < len; k++) begin
          offer_beat(draw_sample(k == len - 1), 1'b0, '0);
          pace();
        end
        phase_beats += len;
      end
    end

    // Short tail back at the reset threshold
    set_threshold(THRESH_RESET);
    repeat (20) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        offer_beat(draw_sample(k == len - 1), 1'b0, '0);
        pace();
      end
    end
    settle();

    $display("Run covered %0d beats in %0d tensors over %0d threshold writes; %0d means checked.",
             beats_sent, tensors_closed, thresh_writes, means_checked);
    $display("Widest tensor held %0d elements; %0d mismatches.", widest_tensor, errors);
    if (errors == 0) $display("tb_huber_loss_mean_reducer passed");
    else $display("tb_huber_loss_mean_reducer failed");
    $finish;
  end

endmodule
